// File: rtl/krt_pkg.sv
// shared types and codes for the keyed record table
// no dependencies
package krt_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_DELETE = 3'd1;
    localparam logic [2:0] MODE_MODIFY = 3'd2;
    localparam logic [2:0] MODE_QUERY  = 3'd3;
    localparam logic [2:0] MODE_LIST   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [31:0] key;
        logic [7:0]  age;
        logic [63:0] name;
        logic [63:0] career;
    } t_record;

    typedef struct packed {
        logic rot;
        logic we;
    } t_cell_ctl;

endpackage

// File: rtl/keyed_record_table.sv
// keyed record table: insert and empty-list items strobe in the cycle after start, busy low;
// unused modes give nothing; query, modify and a missed key run FIND1, FIND2, ACT while busy
// and strobe from the result register after ACT; delete strobes alike, busy in MOVE as the
// last entry fills the freed slot; list, busy in LIST, rotates all slots, one entry per cycle.
// results cannot be stalled. synchronous active-low reset empties the table, records keep none
// depends on krt_pkg, krt_cell, krt_find
module keyed_record_table #(
    parameter int CAPACITY = krt_pkg::DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_key,
    input  logic [7:0]         i_age_in,
    input  logic [63:0]        i_name_in,
    input  logic [63:0]        i_career_in,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_key_out,
    output logic [7:0]         o_age_out,
    output logic [63:0]        o_name_out,
    output logic [63:0]        o_career_out,
    output logic               o_last
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND1,
        S_FIND2,
        S_ACT,
        S_MOVE,
        S_LIST
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_lcnt;
    logic [2:0]        r_mode;
    logic [31:0]       r_key;
    logic [7:0]        r_age;
    logic [63:0]       r_name;
    logic [63:0]       r_career;

    logic              r_valid;
    logic              n_valid;
    logic [1:0]        r_status;
    krt_pkg::t_record  r_out;
    logic              r_last;

    krt_pkg::t_record  w_cell_rec [CAPACITY];
    logic [CAPACITY-1:0] w_hit;
    krt_pkg::t_cell_ctl w_ctl [CAPACITY];
    krt_pkg::t_record  w_wr_rec;
    krt_pkg::t_record  w_rd_rec;
    krt_pkg::t_record  w_in_rec;
    logic              w_wr_en;
    logic [IW-1:0]     w_wr_idx;
    logic [IW-1:0]     w_rd_idx;
    logic              w_found;
    logic [IW-1:0]     w_pos;
    logic              w_accept;
    logic              w_room;

    assign w_accept = start && (r_state == S_IDLE);
    assign w_room   = r_count < CW'(CAPACITY);
    assign w_in_rec = '{key: i_key, age: i_age_in, name: i_name_in, career: i_career_in};

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        krt_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl[i]),
            .i_wr_rec (w_wr_rec),
            .i_next   (w_cell_rec[(i + 1) % CAPACITY]),
            .i_key    (r_key),
            .i_live   (CW'(i) < r_count),
            .o_rec    (w_cell_rec[i]),
            .o_hit    (w_hit[i])
        );
    end

    krt_find #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_find (
        .i_clk   (i_clk),
        .i_hit   (w_hit),
        .o_found (w_found),
        .o_pos   (w_pos)
    );

    assign w_rd_idx = (r_state == S_MOVE) ? IW'(r_count - CW'(1)) : w_pos;
    assign w_rd_rec = w_cell_rec[w_rd_idx];

    // result strobe for the coming cycle
    assign n_valid = (w_accept && ((i_mode == krt_pkg::MODE_INSERT) ||
                                   ((i_mode == krt_pkg::MODE_LIST) && (r_count == '0)))) ||
                     (r_state == S_ACT) ||
                     ((r_state == S_LIST) && (r_lcnt < r_count));

    // write port of the cell row
    always_comb begin
        w_wr_en  = 1'b0;
        w_wr_idx = w_pos;
        w_wr_rec = w_rd_rec;
        case (r_state)
            S_IDLE: begin
                w_wr_en  = w_accept && (i_mode == krt_pkg::MODE_INSERT) && w_room;
                w_wr_idx = IW'(r_count);
                w_wr_rec = w_in_rec;
            end
            S_ACT: begin
                w_wr_en  = w_found && (r_mode == krt_pkg::MODE_MODIFY);
                w_wr_rec = '{key: w_rd_rec.key, age: r_age, name: r_name, career: r_career};
            end
            S_MOVE: begin
                w_wr_en = 1'b1;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
        for (int i = 0; i < CAPACITY; i++) begin
            w_ctl[i].rot = (r_state == S_LIST);
            w_ctl[i].we  = w_wr_en && (w_wr_idx == IW'(i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_lcnt  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode   <= i_mode;
                        r_key    <= i_key;
                        r_age    <= i_age_in;
                        r_name   <= i_name_in;
                        r_career <= i_career_in;
                        r_last   <= 1'b1;
                        case (i_mode)
                            krt_pkg::MODE_INSERT: begin
                                if (w_room) begin
                                    r_status <= krt_pkg::ST_OK;
                                    r_out    <= w_in_rec;
                                    r_count  <= r_count + CW'(1);
                                end else begin
                                    r_status <= krt_pkg::ST_FULL;
                                    r_out    <= '0;
                                end
                            end
                            krt_pkg::MODE_LIST: begin
                                if (r_count == '0) begin
                                    r_status <= krt_pkg::ST_EMPTY;
                                    r_out    <= '0;
                                end else begin
                                    r_lcnt  <= '0;
                                    r_state <= S_LIST;
                                end
                            end
                            krt_pkg::MODE_DELETE, krt_pkg::MODE_MODIFY,
                            krt_pkg::MODE_QUERY: begin
                                r_state <= S_FIND1;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_FIND1: begin
                    r_state <= S_FIND2;
                end
                S_FIND2: begin
                    r_state <= S_ACT;
                end
                S_ACT: begin
                    r_last <= 1'b1;
                    if (!w_found) begin
                        r_status <= krt_pkg::ST_NOT_FOUND;
                        r_out    <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_status <= krt_pkg::ST_OK;
                        case (r_mode)
                            krt_pkg::MODE_DELETE: begin
                                r_out   <= w_rd_rec;
                                r_state <= S_MOVE;
                            end
                            krt_pkg::MODE_MODIFY: begin
                                r_out   <= w_wr_rec;
                                r_state <= S_IDLE;
                            end
                            default: begin
                                r_out   <= w_rd_rec;
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_MOVE: begin
                    r_count <= r_count - CW'(1);
                    r_state <= S_IDLE;
                end
                S_LIST: begin
                    if (r_lcnt < r_count) begin
                        r_status <= krt_pkg::ST_OK;
                        r_out    <= w_cell_rec[0];
                        r_last   <= (r_lcnt == r_count - CW'(1));
                    end
                    if (r_lcnt == CW'(CAPACITY - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_lcnt <= r_lcnt + CW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_key_out    = r_out.key;
    assign o_age_out    = r_out.age;
    assign o_name_out   = r_out.name;
    assign o_career_out = r_out.career;
    assign o_last       = r_last;

endmodule

// File: rtl/krt_cell.sv
// one table slot: record register, key compare, ring shift link
// depends on krt_pkg
module krt_cell (
    input  logic                i_clk,
    input  krt_pkg::t_cell_ctl  i_ctl,
    input  krt_pkg::t_record    i_wr_rec,
    input  krt_pkg::t_record    i_next,
    input  logic [31:0]         i_key,
    input  logic                i_live,
    output krt_pkg::t_record    o_rec,
    output logic                o_hit
);

    krt_pkg::t_record r_rec;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rot) begin
            r_rec <= i_next;
        end else if (i_ctl.we) begin
            r_rec <= i_wr_rec;
        end
    end

    assign o_rec = r_rec;
    assign o_hit = i_live && (r_rec.key == i_key);

endmodule

// File: rtl/krt_find.sv
// two-stage registered first-match encoder over the cell hit vector
// depends on nothing beyond its parameter
module krt_find #(
    parameter int CAPACITY = 64,
    parameter int IW       = 6
) (
    input  logic                i_clk,
    input  logic [CAPACITY-1:0] i_hit,
    output logic                o_found,
    output logic [IW-1:0]       o_pos
);

    localparam int NGRP = (CAPACITY + 7) / 8;
    localparam int PADW = NGRP * 8;

    logic [PADW-1:0] w_hits;
    logic [NGRP-1:0] n_any;
    logic [NGRP-1:0] r_any;
    logic [2:0]      n_sub [NGRP];
    logic [2:0]      r_sub [NGRP];
    logic            n_found;
    logic [IW-1:0]   n_pos;
    logic            r_found;
    logic [IW-1:0]   r_pos;

    assign w_hits = PADW'(i_hit);

    // first stage: lowest hit inside each group of eight
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_any[g] = |w_hits[g*8 +: 8];
            n_sub[g] = '0;
            for (int j = 7; j >= 0; j--) begin
                if (w_hits[g*8 + j]) begin
                    n_sub[g] = 3'(j);
                end
            end
        end
    end

    // second stage: lowest group with a hit
    always_comb begin
        n_found = |r_any;
        n_pos   = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_any[g]) begin
                n_pos = IW'(g * 8 + int'(r_sub[g]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_any   <= n_any;
        r_sub   <= n_sub;
        r_found <= n_found;
        r_pos   <= n_pos;
    end

    assign o_found = r_found;
    assign o_pos   = r_pos;

endmodule
